@@ src/hsv2rgb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies; imported by every module of the converter.
package hsv2rgb_pkg;

    // Field widths of the pixel interface.
    localparam int HUE_W    = 16;
    localparam int PIX_W    = 13;

    // Default fraction width of saturation, value and the color channels.
    localparam int FRAC_BITS_DEF = 12;

    // Hue scaling: h1 = (hue * 3/pi in Q24) >> 24, with h1 in Q.13.
    localparam int           SCALE_W     = 24;
    localparam logic [23:0]  HUE_SCALE   = 24'd16021061;
    localparam int           HPROD_W     = HUE_W + SCALE_W;
    localparam int           HUE_FRAC    = 13;
    localparam int           SECTOR_W    = 3;
    localparam int           WEIGHT_W    = HUE_FRAC + 1;
    localparam logic [13:0]  WEIGHT_ONE  = 14'd8192;

    // Product widths.
    localparam int CPROD_W  = 2 * PIX_W;
    localparam int XPROD_W  = PIX_W + WEIGHT_W;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [PIX_W-1:0] saturation;
        logic [PIX_W-1:0] brightness;
    } t_hsv_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb_pixel;

    // After both front multipliers.
    typedef struct packed {
        logic [HPROD_W-1:0] hue_prod;
        logic [CPROD_W-1:0] chroma_prod;
        logic [PIX_W-1:0]   bright;
    } t_prod_stage;

    // Ready for the channel mix.
    typedef struct packed {
        t_sector          sector;
        logic [PIX_W-1:0] x_val;
        logic [PIX_W-1:0] chroma;
        logic [PIX_W-1:0] offset;
    } t_mix_stage;

endpackage

@@ src/hsv_to_rgb_converter.sv @@
`timescale 1ns / 1ps
// HSV to RGB pixel converter, five register stages: clamp, two multipliers,
// sector and weight, x multiplier, channel mix into the output register.
// Takes one pixel per cycle while the output is not stalled.
// Each stage holds its transaction while stalled, so a full pipeline stops without loss.
// Synchronous active-low reset clears all valid bits; the pipeline is empty afterwards.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_hsv_pixel i_pixel,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rgb_pixel o_rgb
);

    logic        front_valid;
    logic        front_ready;
    t_prod_stage front_data;
    logic        weight_valid;
    logic        weight_ready;
    t_mix_stage  weight_data;

    hsv2rgb_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_data  (front_data)
    );

    hsv2rgb_weight #(
        .FRAC_BITS(FRAC_BITS)
    ) u_weight (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_data),
        .o_valid (weight_valid),
        .i_ready (weight_ready),
        .o_data  (weight_data)
    );

    hsv2rgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (weight_valid),
        .o_ready (weight_ready),
        .i_data  (weight_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_rgb)
    );

endmodule

@@ src/hsv2rgb_front.sv @@
`timescale 1ns / 1ps
// Front end: input clamping register, then the hue scaling and chroma multipliers.
// Depends on hsv2rgb_pkg.
module hsv2rgb_front
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_hsv_pixel  i_pixel,
    output logic        o_valid,
    input  logic        i_ready,
    output t_prod_stage o_data
);

    localparam int CMP_W = (FRAC_BITS + 1 > PIX_W) ? FRAC_BITS + 1 : PIX_W;
    localparam logic [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;

    logic        r_s1_valid;
    t_hsv_pixel  r_s1;
    t_hsv_pixel  n_s1;
    logic        r_s2_valid;
    t_prod_stage r_s2;
    t_prod_stage n_s2;
    logic        ready1;
    logic        ready2;

    assign ready2  = !r_s2_valid || i_ready;
    assign ready1  = !r_s1_valid || ready2;
    assign o_ready = ready1;
    assign o_valid = r_s2_valid;
    assign o_data  = r_s2;

    // Saturation and value above 1.0 are clamped to 1.0.
    always_comb begin
        n_s1.hue        = i_pixel.hue;
        n_s1.saturation = (CMP_W'(i_pixel.saturation) > ONE) ? PIX_W'(ONE)
                                                              : i_pixel.saturation;
        n_s1.brightness = (CMP_W'(i_pixel.brightness) > ONE) ? PIX_W'(ONE)
                                                              : i_pixel.brightness;
    end

    always_comb begin
        n_s2.hue_prod    = HPROD_W'(r_s1.hue) * HPROD_W'(HUE_SCALE);
        n_s2.chroma_prod = CPROD_W'(r_s1.saturation) * CPROD_W'(r_s1.brightness);
        n_s2.bright      = r_s1.brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (ready1) r_s1_valid <= i_valid;
            if (ready2) r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) r_s1 <= n_s1;
        if (ready2 && r_s1_valid) r_s2 <= n_s2;
    end

endmodule

@@ src/hsv2rgb_weight.sv @@
`timescale 1ns / 1ps
// Sector decode and hue weight, then the x = c * w multiplier and m = v - c.
// Depends on hsv2rgb_pkg.
module hsv2rgb_weight
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_prod_stage i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_mix_stage  o_data
);

    typedef struct packed {
        t_sector             sector;
        logic [WEIGHT_W-1:0] weight;
        logic [PIX_W-1:0]    chroma;
        logic [PIX_W-1:0]    bright;
    } t_weight_stage;

    logic                r_s3_valid;
    t_weight_stage       r_s3;
    t_weight_stage       n_s3;
    logic                r_s4_valid;
    t_mix_stage          r_s4;
    t_mix_stage          n_s4;
    logic                ready3;
    logic                ready4;
    logic [SECTOR_W-1:0] raw_sector;
    logic [HUE_FRAC-1:0] frac;
    logic [XPROD_W-1:0]  x_prod;

    assign ready4  = !r_s4_valid || i_ready;
    assign ready3  = !r_s3_valid || ready4;
    assign o_ready = ready3;
    assign o_valid = r_s4_valid;
    assign o_data  = r_s4;

    assign raw_sector = i_data.hue_prod[HPROD_W-1 -: SECTOR_W];
    assign frac       = i_data.hue_prod[SCALE_W +: HUE_FRAC];

    // A full turn or more lands in sector 6 or 7; those wrap back to 0 and 1.
    // The weight keeps the parity of the unwrapped sector, which agrees.
    always_comb begin
        n_s3.weight = raw_sector[0] ? (WEIGHT_ONE - WEIGHT_W'(frac)) : WEIGHT_W'(frac);
        n_s3.chroma = PIX_W'(i_data.chroma_prod >> FRAC_BITS);
        n_s3.bright = i_data.bright;
        unique case (raw_sector)
            3'd0:    n_s3.sector = SECTOR_0;
            3'd1:    n_s3.sector = SECTOR_1;
            3'd2:    n_s3.sector = SECTOR_2;
            3'd3:    n_s3.sector = SECTOR_3;
            3'd4:    n_s3.sector = SECTOR_4;
            3'd5:    n_s3.sector = SECTOR_5;
            3'd6:    n_s3.sector = SECTOR_0;
            default: n_s3.sector = SECTOR_1;
        endcase
    end

    assign x_prod = XPROD_W'(r_s3.chroma) * XPROD_W'(r_s3.weight);

    always_comb begin
        n_s4.sector = r_s3.sector;
        n_s4.x_val  = PIX_W'(x_prod >> HUE_FRAC);
        n_s4.chroma = r_s3.chroma;
        n_s4.offset = r_s3.bright - r_s3.chroma;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (ready3) r_s3_valid <= i_valid;
            if (ready4) r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && i_valid) r_s3 <= n_s3;
        if (ready4 && r_s3_valid) r_s4 <= n_s4;
    end

endmodule

@@ src/hsv2rgb_mix.sv @@
`timescale 1ns / 1ps
// Channel mix: sector permutation of (c, x, 0) plus m, into the output register.
// Depends on hsv2rgb_pkg.
module hsv2rgb_mix
    import hsv2rgb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_mix_stage i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rgb_pixel o_data
);

    logic             r_valid;
    t_rgb_pixel       r_rgb;
    t_rgb_pixel       n_rgb;
    logic [PIX_W-1:0] red_base;
    logic [PIX_W-1:0] green_base;
    logic [PIX_W-1:0] blue_base;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_rgb;

    always_comb begin
        unique case (i_data.sector)
            SECTOR_0: begin
                red_base = i_data.chroma; green_base = i_data.x_val;  blue_base = '0;
            end
            SECTOR_1: begin
                red_base = i_data.x_val;  green_base = i_data.chroma; blue_base = '0;
            end
            SECTOR_2: begin
                red_base = '0; green_base = i_data.chroma; blue_base = i_data.x_val;
            end
            SECTOR_3: begin
                red_base = '0; green_base = i_data.x_val;  blue_base = i_data.chroma;
            end
            SECTOR_4: begin
                red_base = i_data.x_val;  green_base = '0; blue_base = i_data.chroma;
            end
            default: begin
                red_base = i_data.chroma; green_base = '0; blue_base = i_data.x_val;
            end
        endcase
        n_rgb.red   = red_base + i_data.offset;
        n_rgb.green = green_base + i_data.offset;
        n_rgb.blue  = blue_base + i_data.offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_rgb <= n_rgb;
    end

endmodule

@@ src/hsv2rgb_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the HSV to RGB converter, bound to the top level.
// Depends on hsv2rgb_pkg.
module hsv2rgb_checker
    import hsv2rgb_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input t_hsv_pixel i_pixel,
    input logic       o_valid,
    input logic       i_ready,
    input t_rgb_pixel o_rgb
);

    // A stalled result transaction holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rgb))
        else $error("output transaction changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    // Bubbles collapse: an empty output stage or a ready sink means the input is ready.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || i_ready |-> o_ready)
        else $error("input stalled although the pipeline can advance");

    // With the sink ready throughout, an accepted transaction passes every register stage and reaches the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3) &&
        $past(i_rst_n, 4) && $past(i_rst_n, 5) &&
        $past(i_ready, 1) && $past(i_ready, 2) && $past(i_ready, 3) &&
        $past(i_ready, 4) && $past(i_valid && o_ready, 5) |-> o_valid)
        else $error("transaction did not reach the output in five cycles");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (.*);

@@ tb/tb_hsv_to_rgb_converter.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for hsv_to_rgb_converter: directed pixels, then random phases
// with sender gaps and receiver stalls. Depends on hsv2rgb_pkg and the converter RTL.
module tb_hsv_to_rgb_converter;
    import hsv2rgb_pkg::*;

    localparam int          FRAC_BITS   = FRAC_BITS_DEF;
    localparam logic [12:0] UNIT        = 13'(1 << FRAC_BITS);
    localparam int          PIPE_CYCLES = 5;
    localparam int          RAND_ITEMS  = 488;
    localparam int          HUE_TURN    = 51472;
    localparam int          SECTOR_SPAN = 8579;

    typedef struct packed {
        logic       typed;
        t_hsv_pixel hsv;
        t_rgb_pixel rgb;
    } t_pixel_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_hsv_pixel i_pixel;
    logic       o_valid;
    logic       i_ready;
    t_rgb_pixel o_rgb;

    t_rgb_pixel rgb_expect_q[$];
    t_rgb_pixel pending_rgb;
    t_pixel_row directed_rows[$];
    int         pixels_in;
    int         mismatch_cnt;
    int         send_idle_pct;
    int         recv_stall_pct;

    hsv_to_rgb_converter #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rgb   (o_rgb)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [12:0] clamp_unit(logic [12:0] a);
        return (a > UNIT) ? UNIT : a;
    endfunction

    // Fixed-point HSV to RGB with the hue scaled by 3/pi in Q24.
    function automatic t_rgb_pixel predict_rgb(t_hsv_pixel px);
        logic [39:0] hue_scaled;
        logic [15:0] h1;
        logic [2:0]  raw_sector;
        t_sector     sector;
        logic [12:0] frac;
        logic [13:0] weight;
        logic [12:0] sat;
        logic [12:0] val;
        logic [25:0] chroma_full;
        logic [12:0] chroma;
        logic [26:0] x_full;
        logic [12:0] x_val;
        logic [12:0] offset;
        logic [12:0] r;
        logic [12:0] g;
        logic [12:0] b;
        t_rgb_pixel  res;
        hue_scaled  = 40'(px.hue) * 40'(HUE_SCALE);
        h1          = hue_scaled[39:24];
        raw_sector  = h1[15:13];
        frac        = h1[12:0];
        weight      = raw_sector[0] ? (WEIGHT_ONE - 14'(frac)) : 14'(frac);
        sat         = clamp_unit(px.saturation);
        val         = clamp_unit(px.brightness);
        chroma_full = 26'(sat) * 26'(val);
        chroma      = 13'(chroma_full >> FRAC_BITS);
        x_full      = 27'(chroma) * 27'(weight);
        x_val       = 13'(x_full >> HUE_FRAC);
        offset      = val - chroma;
        // A hue at or past a full turn lands in sector 6 or 7 and wraps around.
        sector = t_sector'((raw_sector >= 3'd6) ? raw_sector - 3'd6 : raw_sector);
        case (sector)
            SECTOR_0: begin r = chroma; g = x_val;  b = '0;     end
            SECTOR_1: begin r = x_val;  g = chroma; b = '0;     end
            SECTOR_2: begin r = '0;     g = chroma; b = x_val;  end
            SECTOR_3: begin r = '0;     g = x_val;  b = chroma; end
            SECTOR_4: begin r = x_val;  g = '0;     b = chroma; end
            default:  begin r = chroma; g = '0;     b = x_val;  end
        endcase
        res.red   = r + offset;
        res.green = g + offset;
        res.blue  = b + offset;
        return res;
    endfunction

    function automatic logic [12:0] pick_level(int full_range);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return '0;
        if (sel == 1) return UNIT;
        if (full_range != 0) return 13'($urandom_range(8191));
        return 13'($urandom_range(int'(UNIT)));
    endfunction

    function automatic t_hsv_pixel random_pixel();
        t_hsv_pixel px;
        int         sel;
        int         h;
        sel = $urandom_range(99);
        if (sel < 70) begin
            px.hue        = 16'($urandom_range(HUE_TURN));
            px.saturation = pick_level(0);
            px.brightness = pick_level(0);
        end else if (sel < 82) begin
            px.hue        = 16'($urandom_range(65535));
            px.saturation = 13'($urandom_range(8191));
            px.brightness = 13'($urandom_range(8191));
        end else if (sel < 92) begin
            // Hue right around a sector boundary.
            h = $urandom_range(7) * SECTOR_SPAN + $urandom_range(6) - 3;
            px.hue        = 16'((h < 0) ? 0 : h);
            px.saturation = pick_level(1);
            px.brightness = pick_level(1);
        end else begin
            px.hue        = 16'($urandom_range(65535, HUE_TURN - 2));
            px.saturation = 13'($urandom_range(8191, int'(UNIT) - 4));
            px.brightness = 13'($urandom_range(8191, int'(UNIT) - 4));
        end
        return px;
    endfunction

    task automatic add_row(int hue, int sat, int val, bit typed, int r, int g, int b);
        t_pixel_row row;
        row.typed          = typed;
        row.hsv.hue        = 16'(hue);
        row.hsv.saturation = 13'(sat);
        row.hsv.brightness = 13'(val);
        row.rgb.red        = 13'(r);
        row.rgb.green      = 13'(g);
        row.rgb.blue       = 13'(b);
        directed_rows.push_back(row);
    endtask

    // Drives one pixel from a falling edge and returns once the transaction is taken.
    task automatic send_pixel(t_hsv_pixel px, t_rgb_pixel rgb);
        int taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        taken       = pixels_in + 1;
        pending_rgb = rgb;
        i_pixel     = px;
        i_valid     = 1'b1;
        do @(negedge i_clk); while (pixels_in != taken);
    endtask

    task automatic drain_results();
        i_valid = 1'b0;
        while (rgb_expect_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic check_channel(string name, logic [12:0] want, logic [12:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Output check first, then the input transaction of the same edge is queued.
    always @(posedge i_clk) begin
        t_rgb_pixel want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (rgb_expect_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                             $time, o_rgb.red, o_rgb.green, o_rgb.blue);
                    mismatch_cnt++;
                end else begin
                    want = rgb_expect_q.pop_front();
                    check_channel("red", want.red, o_rgb.red);
                    check_channel("green", want.green, o_rgb.green);
                    check_channel("blue", want.blue, o_rgb.blue);
                end
            end
            if (i_valid && o_ready) begin
                rgb_expect_q.push_back(pending_rgb);
                pixels_in++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int phase;
        t_hsv_pixel px;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_pixel        = '0;
        i_ready        = 1'b0;
        pending_rgb    = '0;
        pixels_in      = 0;
        mismatch_cnt   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        add_row(0, 0, 0, 1, 0, 0, 0);
        add_row(0, 0, 4096, 1, 4096, 4096, 4096);
        add_row(0, 4096, 4096, 1, 4096, 0, 0);
        add_row(0, 8191, 8191, 1, 4096, 0, 0);
        add_row(HUE_TURN, 4096, 0, 1, 0, 0, 0);
        add_row(65535, 0, 8191, 1, 4096, 4096, 4096);
        add_row(65535, 8191, 0, 1, 0, 0, 0);
        add_row(65535, 8191, 8191, 0, 0, 0, 0);
        add_row(HUE_TURN, 4096, 4096, 0, 0, 0, 0);
        add_row(HUE_TURN - 1, 4096, 4096, 0, 0, 0, 0);
        add_row(4289, 4096, 4096, 0, 0, 0, 0);
        add_row(12868, 4096, 4096, 0, 0, 0, 0);
        add_row(21447, 4096, 4096, 0, 0, 0, 0);
        add_row(30025, 4096, 4096, 0, 0, 0, 0);
        add_row(38604, 4096, 4096, 0, 0, 0, 0);
        add_row(47183, 4096, 4096, 0, 0, 0, 0);
        add_row(SECTOR_SPAN, 3000, 3500, 0, 0, 0, 0);
        add_row(2 * SECTOR_SPAN - 1, 3000, 3500, 0, 0, 0, 0);
        add_row(3 * SECTOR_SPAN, 3000, 3500, 0, 0, 0, 0);
        add_row(4 * SECTOR_SPAN + 1, 3000, 3500, 0, 0, 0, 0);
        add_row(5 * SECTOR_SPAN, 3000, 3500, 0, 0, 0, 0);
        add_row(4289, 4097, 4097, 0, 0, 0, 0);
        add_row(30025, 1, 8191, 0, 0, 0, 0);
        add_row(12868, 2048, 4096, 0, 0, 0, 0);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            send_pixel(directed_rows[k].hsv,
                       directed_rows[k].typed ? directed_rows[k].rgb
                                              : predict_rgb(directed_rows[k].hsv));
        end
        drain_results();

        // Phases: free running, slow sender, slow receiver, both mildly busy.
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 82 : (phase == 3) ? 10 : 0;
            recv_stall_pct = (phase == 2) ? 82 : (phase == 3) ? 10 : 0;
            repeat (RAND_ITEMS) begin
                px = random_pixel();
                send_pixel(px, predict_rgb(px));
            end
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (4 * PIPE_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0 && rgb_expect_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
